// File: rtl/qdrs_pkg.sv
package qdrs_pkg;

    localparam int UNIVERSE     = 1024;
    localparam int BUFFER_DEPTH = 256;

    localparam int LOG_U  = $clog2(UNIVERSE);
    localparam int NODES  = 2 * UNIVERSE - 1;
    localparam int IDX_W  = $clog2(NODES);
    localparam int DEP_W  = $clog2(LOG_U + 1);
    localparam int BUF_AW = $clog2(BUFFER_DEPTH);
    localparam int CNT_W  = BUF_AW + 1;

    localparam int VAL_W  = 10;
    localparam int WGT_W  = 16;
    localparam int DIV_W  = 9;
    localparam int RANK_W = 31;
    localparam int TOT_W  = 32;
    localparam int SUM_W  = TOT_W + IDX_W;   // subtree sum never wraps
    localparam int DEBT_W = SUM_W + 3;       // signed debt carried in compression

    localparam logic [DIV_W-1:0]  DIV_RESET = DIV_W'(100);
    localparam logic [TOT_W-1:0]  MAX32     = {TOT_W{1'b1}};
    localparam logic [RANK_W-1:0] RANK_MAX  = {RANK_W{1'b1}};

    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_QUERY  = 1'b1;

    // compression context handed from parent to child
    localparam logic [1:0] M_ACT  = 2'd0;
    localparam logic [1:0] M_ZERO = 2'd1;
    localparam logic [1:0] M_SKIP = 2'd2;

    typedef logic signed [DEBT_W:0] wide_t;

    function automatic logic [TOT_W-1:0] sat32(input wide_t v);
        logic [TOT_W-1:0] r;
        if (v < 0) begin
            r = '0;
        end else if (v > $signed({{(DEBT_W+1-TOT_W){1'b0}}, MAX32})) begin
            r = MAX32;
        end else begin
            r = v[TOT_W-1:0];
        end
        return r;
    endfunction

endpackage

// File: rtl/qdrs_div.sv
module qdrs_div (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       start,
    input  logic [qdrs_pkg::TOT_W-1:0] dividend,
    input  logic [qdrs_pkg::DIV_W-1:0] divisor,
    output logic                       done,
    output logic [qdrs_pkg::TOT_W-1:0] quotient
);
    import qdrs_pkg::*;

    localparam int CW = $clog2(TOT_W + 1);

    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [CW-1:0]    cnt_reg, cnt_next;
    logic [TOT_W-1:0] q_reg, q_next;
    logic [DIV_W-1:0] r_reg, r_next;
    logic [DIV_W-1:0] d_reg, d_next;
    logic [DIV_W:0]   trial;
    logic [DIV_W:0]   diff;
    logic             ge;

    // restoring division, one quotient bit per cycle
    assign trial = {r_reg, q_reg[TOT_W-1]};
    assign ge    = trial >= {1'b0, d_reg};
    assign diff  = trial - {1'b0, d_reg};

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        q_next    = q_reg;
        r_next    = r_reg;
        d_next    = d_reg;
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = '0;
            q_next    = dividend;
            r_next    = '0;
            d_next    = divisor;
        end else if (busy_reg) begin
            q_next   = {q_reg[TOT_W-2:0], ge};
            r_next   = ge ? diff[DIV_W-1:0] : trial[DIV_W-1:0];
            cnt_next = cnt_reg + CW'(1);
            if (cnt_reg == CW'(TOT_W - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        q_reg <= q_next;
        r_reg <= r_next;
        d_reg <= d_next;
    end

    assign done     = done_reg;
    assign quotient = q_reg;

endmodule

// File: rtl/qdrs_core.sv
module qdrs_core (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic                        in_op,
    input  logic [qdrs_pkg::VAL_W-1:0]  in_value,
    input  logic [qdrs_pkg::WGT_W-1:0]  in_weight,
    input  logic [qdrs_pkg::DIV_W-1:0]  divisor,
    output logic                        res_valid,
    input  logic                        res_ready,
    output logic [qdrs_pkg::RANK_W-1:0] res_rank
);
    import qdrs_pkg::*;

    localparam int BW = VAL_W + WGT_W;
    localparam int MW = 2 + DEBT_W;

    localparam logic [4:0] S_CLEAR  = 5'd0;
    localparam logic [4:0] S_IDLE   = 5'd1;
    localparam logic [4:0] S_BI_RD  = 5'd2;
    localparam logic [4:0] S_BI_CMP = 5'd3;
    localparam logic [4:0] S_BI_WR  = 5'd4;
    localparam logic [4:0] S_FL     = 5'd5;
    localparam logic [4:0] S_FL_LD  = 5'd6;
    localparam logic [4:0] S_TU_ADD = 5'd7;
    localparam logic [4:0] S_TU_DIV = 5'd8;
    localparam logic [4:0] S_TU_RD  = 5'd9;
    localparam logic [4:0] S_TU_ST  = 5'd10;
    localparam logic [4:0] S_UP_RDW = 5'd11;
    localparam logic [4:0] S_UP_L   = 5'd12;
    localparam logic [4:0] S_UP_R   = 5'd13;
    localparam logic [4:0] S_UP_SUM = 5'd14;
    localparam logic [4:0] S_UP_WR  = 5'd15;
    localparam logic [4:0] S_TU_CHK = 5'd16;
    localparam logic [4:0] S_TU_END = 5'd17;
    localparam logic [4:0] S_CP_RD  = 5'd18;
    localparam logic [4:0] S_CP_A   = 5'd19;
    localparam logic [4:0] S_CP_B   = 5'd20;
    localparam logic [4:0] S_CP_WL  = 5'd21;
    localparam logic [4:0] S_CP_WR  = 5'd22;
    localparam logic [4:0] S_CP_NX  = 5'd23;
    localparam logic [4:0] S_QT     = 5'd24;
    localparam logic [4:0] S_QT_ADD = 5'd25;
    localparam logic [4:0] S_QB     = 5'd26;
    localparam logic [4:0] S_QB_CHK = 5'd27;
    localparam logic [4:0] S_RES    = 5'd28;

    // node weights, subtree sums, compression context, insert buffer
    logic [TOT_W-1:0] wmem [NODES];
    logic [SUM_W-1:0] smem [NODES];
    logic [MW-1:0]    mmem [NODES];
    logic [BW-1:0]    bmem [BUFFER_DEPTH];

    logic             w_we, s_we, m_we, b_we;
    logic [IDX_W-1:0] w_waddr, w_raddr, s_waddr, s_raddr, m_waddr, m_raddr;
    logic [BUF_AW-1:0] b_waddr, b_raddr;
    logic [TOT_W-1:0] w_wdata, w_rd;
    logic [SUM_W-1:0] s_wdata, s_rd;
    logic [MW-1:0]    m_wdata, m_rd;
    logic [BW-1:0]    b_wdata, b_rd;

    always_ff @(posedge aclk) begin
        if (w_we) wmem[w_waddr] <= w_wdata;
        w_rd <= wmem[w_raddr];
    end
    always_ff @(posedge aclk) begin
        if (s_we) smem[s_waddr] <= s_wdata;
        s_rd <= smem[s_raddr];
    end
    always_ff @(posedge aclk) begin
        if (m_we) mmem[m_waddr] <= m_wdata;
        m_rd <= mmem[m_raddr];
    end
    always_ff @(posedge aclk) begin
        if (b_we) bmem[b_waddr] <= b_wdata;
        b_rd <= bmem[b_raddr];
    end

    logic [4:0]       state_reg, state_next;
    logic [VAL_W-1:0] x_reg, x_next;
    logic [WGT_W-1:0] wt_reg, wt_next;
    logic [TOT_W-1:0] total_reg, total_next;
    logic [TOT_W-1:0] cap_reg, cap_next;
    logic [TOT_W-1:0] ceil_reg, ceil_next;
    logic             flushed_reg, flushed_next;
    logic [CNT_W-1:0] bcnt_reg, bcnt_next;
    logic [IDX_W-1:0] idx_reg, idx_next;
    logic [DEP_W-1:0] depth_reg, depth_next;
    logic [WGT_W-1:0] rem_reg, rem_next;
    logic [CNT_W-1:0] k_reg, k_next;
    logic [SUM_W-1:0] acc_reg, acc_next;
    logic             flushing_reg, flushing_next;
    logic             rebuild_reg, rebuild_next;
    logic [TOT_W-1:0] wsave_reg, wsave_next;
    logic [SUM_W-1:0] part_reg, part_next;
    logic [1:0]       cmode_reg, cmode_next;
    wide_t            diff_reg, diff_next;
    wide_t            dp_reg, dp_next;
    logic [1:0]       cml_reg, cml_next, cmr_reg, cmr_next;
    logic [DEBT_W-1:0] dl_reg, dl_next, dr_reg, dr_next;

    logic             div_start, div_done;
    logic [TOT_W-1:0] div_dividend, div_quo;
    logic [DIV_W-1:0] eff_div;

    assign eff_div = (divisor == '0) ? DIV_W'(1) : divisor;

    qdrs_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (eff_div),
        .done     (div_done),
        .quotient (div_quo)
    );

    logic [IDX_W-1:0] lchild, rchild, parent;
    logic             is_leaf;
    logic [VAL_W-1:0] bv;
    logic [WGT_W-1:0] bw;

    assign lchild  = IDX_W'({idx_reg, 1'b1});
    assign rchild  = lchild + IDX_W'(1);
    assign parent  = IDX_W'((idx_reg - IDX_W'(1)) >> 1);
    assign is_leaf = idx_reg >= IDX_W'(UNIVERSE - 1);
    assign bv      = b_rd[WGT_W +: VAL_W];
    assign bw      = b_rd[WGT_W-1:0];

    always_comb begin
        logic             buffered;
        logic             x_out;
        logic             go_right;
        logic [TOT_W:0]   tsum;
        logic [TOT_W-1:0] tsat;
        logic [TOT_W-1:0] gap;
        logic [WGT_W-1:0] dstep;
        logic [TOT_W:0]   lsum;
        wide_t            debt_cur;
        wide_t            capx, lsx, rdt, dlw;
        logic [TOT_W-1:0] wnew;

        state_next    = state_reg;
        x_next        = x_reg;
        wt_next       = wt_reg;
        total_next    = total_reg;
        cap_next      = cap_reg;
        ceil_next     = ceil_reg;
        flushed_next  = flushed_reg;
        bcnt_next     = bcnt_reg;
        idx_next      = idx_reg;
        depth_next    = depth_reg;
        rem_next      = rem_reg;
        k_next        = k_reg;
        acc_next      = acc_reg;
        flushing_next = flushing_reg;
        rebuild_next  = rebuild_reg;
        wsave_next    = wsave_reg;
        part_next     = part_reg;
        cmode_next    = cmode_reg;
        diff_next     = diff_reg;
        dp_next       = dp_reg;
        cml_next      = cml_reg;
        cmr_next      = cmr_reg;
        dl_next       = dl_reg;
        dr_next       = dr_reg;

        w_we = 1'b0; w_waddr = idx_reg; w_wdata = '0; w_raddr = idx_reg;
        s_we = 1'b0; s_waddr = idx_reg; s_wdata = '0; s_raddr = idx_reg;
        m_we = 1'b0; m_waddr = lchild;  m_wdata = '0; m_raddr = idx_reg;
        b_we = 1'b0; b_waddr = k_reg[BUF_AW-1:0]; b_wdata = '0;
        b_raddr = k_reg[BUF_AW-1:0];

        div_start    = 1'b0;
        in_ready     = 1'b0;
        res_valid    = 1'b0;

        buffered = !flushed_reg && (total_reg < {{(TOT_W-DIV_W){1'b0}}, eff_div});
        x_out    = {1'b0, in_value} >= (VAL_W+1)'(UNIVERSE);
        go_right = x_reg[DEP_W'(LOG_U - 1) - depth_reg];
        tsum     = {1'b0, total_reg} + {{(TOT_W+1-WGT_W){1'b0}}, wt_reg};
        tsat     = tsum[TOT_W] ? MAX32 : tsum[TOT_W-1:0];
        div_dividend = tsat;
        gap      = cap_reg - w_rd;
        dstep    = '0;
        lsum     = '0;
        debt_cur = '0;
        capx     = $signed({{(DEBT_W+1-TOT_W){1'b0}}, cap_reg});
        lsx      = $signed({{(DEBT_W+1-SUM_W){1'b0}}, s_rd});
        rdt      = dp_reg - lsx;
        dlw      = '0;
        wnew     = '0;

        case (state_reg)
            S_CLEAR: begin
                w_we = 1'b1;
                s_we = 1'b1;
                if (idx_reg == IDX_W'(NODES - 1)) begin
                    idx_next   = '0;
                    state_next = S_IDLE;
                end else begin
                    idx_next = idx_reg + IDX_W'(1);
                end
            end

            S_IDLE: begin
                in_ready = 1'b1;
                if (in_valid) begin
                    x_next     = in_value;
                    wt_next    = in_weight;
                    k_next     = '0;
                    acc_next   = '0;
                    idx_next   = '0;
                    depth_next = '0;
                    flushing_next = 1'b0;
                    rebuild_next  = 1'b0;
                    if (in_op == OP_INSERT) begin
                        if (x_out) begin
                            state_next = S_IDLE;
                        end else if (buffered) begin
                            k_next     = bcnt_reg;
                            state_next = S_BI_RD;
                        end else begin
                            state_next = S_TU_ADD;
                        end
                    end else begin
                        if (x_out) begin
                            acc_next   = {{(SUM_W-RANK_W){1'b0}}, RANK_MAX};
                            state_next = S_RES;
                        end else if (buffered) begin
                            state_next = S_QB;
                        end else begin
                            state_next = S_QT;
                        end
                    end
                end
            end

            // sorted insert: shift larger entries up from the end
            S_BI_RD: begin
                b_raddr = BUF_AW'(k_reg - CNT_W'(1));
                if (k_reg == '0) begin
                    state_next = S_BI_WR;
                end else begin
                    state_next = S_BI_CMP;
                end
            end

            S_BI_CMP: begin
                if ((bv < x_reg) || ((bv == x_reg) && (bw <= wt_reg))) begin
                    state_next = S_BI_WR;
                end else begin
                    b_we       = 1'b1;
                    b_wdata    = b_rd;
                    k_next     = k_reg - CNT_W'(1);
                    state_next = S_BI_RD;
                end
            end

            S_BI_WR: begin
                b_we      = 1'b1;
                b_wdata   = {x_reg, wt_reg};
                bcnt_next = bcnt_reg + CNT_W'(1);
                if ((tsat >= {{(TOT_W-DIV_W){1'b0}}, eff_div}) ||
                    (bcnt_reg + CNT_W'(1) >= CNT_W'(BUFFER_DEPTH))) begin
                    total_next = '0;
                    k_next     = '0;
                    state_next = S_FL;
                end else begin
                    total_next = tsat;
                    state_next = S_IDLE;
                end
            end

            S_FL: begin
                if (k_reg < bcnt_reg) begin
                    state_next = S_FL_LD;
                end else begin
                    bcnt_next     = '0;
                    flushed_next  = 1'b1;
                    flushing_next = 1'b0;
                    state_next    = S_IDLE;
                end
            end

            S_FL_LD: begin
                x_next        = bv;
                wt_next       = bw;
                flushing_next = 1'b1;
                state_next    = S_TU_ADD;
            end

            S_TU_ADD: begin
                total_next = tsat;
                div_start  = 1'b1;
                state_next = S_TU_DIV;
            end

            S_TU_DIV: begin
                if (div_done) begin
                    cap_next   = div_quo;
                    idx_next   = '0;
                    depth_next = '0;
                    rem_next   = wt_reg;
                    state_next = S_TU_RD;
                end
            end

            S_TU_RD: begin
                state_next = S_TU_ST;
            end

            // top up node to capacity, rest goes down the path
            S_TU_ST: begin
                w_we = 1'b1;
                if (is_leaf) begin
                    lsum    = {1'b0, w_rd} + {{(TOT_W+1-WGT_W){1'b0}}, rem_reg};
                    w_wdata = lsum[TOT_W] ? MAX32 : lsum[TOT_W-1:0];
                    rebuild_next = 1'b0;
                    state_next   = S_UP_RDW;
                end else begin
                    if (w_rd < cap_reg) begin
                        dstep = (gap < {{(TOT_W-WGT_W){1'b0}}, rem_reg}) ?
                                gap[WGT_W-1:0] : rem_reg;
                    end
                    w_wdata  = w_rd + {{(TOT_W-WGT_W){1'b0}}, dstep};
                    rem_next = rem_reg - dstep;
                    if (rem_reg == dstep) begin
                        rebuild_next = 1'b0;
                        state_next   = S_UP_RDW;
                    end else begin
                        idx_next   = go_right ? rchild : lchild;
                        depth_next = depth_reg + DEP_W'(1);
                        state_next = S_TU_RD;
                    end
                end
            end

            S_UP_RDW: begin
                state_next = S_UP_L;
            end

            S_UP_L: begin
                wsave_next = w_rd;
                s_raddr    = is_leaf ? idx_reg : lchild;
                if (is_leaf) begin
                    part_next  = '0;
                    state_next = S_UP_WR;
                end else begin
                    state_next = S_UP_R;
                end
            end

            S_UP_R: begin
                part_next  = s_rd;
                s_raddr    = rchild;
                state_next = S_UP_SUM;
            end

            S_UP_SUM: begin
                part_next  = part_reg + s_rd;
                state_next = S_UP_WR;
            end

            S_UP_WR: begin
                s_we    = 1'b1;
                s_wdata = {{(SUM_W-TOT_W){1'b0}}, wsave_reg} + part_reg;
                if (rebuild_reg) begin
                    if (idx_reg == '0) begin
                        ceil_next    = total_reg[TOT_W-1] ? MAX32 : {total_reg[TOT_W-2:0], 1'b0};
                        rebuild_next = 1'b0;
                        state_next   = S_TU_END;
                    end else begin
                        idx_next   = idx_reg - IDX_W'(1);
                        state_next = S_UP_RDW;
                    end
                end else begin
                    if (idx_reg == '0) begin
                        state_next = S_TU_CHK;
                    end else begin
                        idx_next   = parent;
                        state_next = S_UP_RDW;
                    end
                end
            end

            S_TU_CHK: begin
                if (total_reg > ceil_reg) begin
                    idx_next   = '0;
                    state_next = S_CP_RD;
                end else begin
                    state_next = S_TU_END;
                end
            end

            S_TU_END: begin
                if (flushing_reg) begin
                    k_next     = k_reg + CNT_W'(1);
                    state_next = S_FL;
                end else begin
                    state_next = S_IDLE;
                end
            end

            // compression sweep in index order; parents hand context to children
            S_CP_RD: begin
                state_next = S_CP_A;
            end

            S_CP_A: begin
                if (idx_reg == '0) begin
                    cmode_next = M_ACT;
                    debt_cur   = '0;
                end else begin
                    cmode_next = m_rd[MW-1 -: 2];
                    debt_cur   = $signed({m_rd[DEBT_W-1], m_rd[DEBT_W-1:0]});
                end
                wsave_next = w_rd;
                diff_next  = $signed({{(DEBT_W+1-SUM_W){1'b0}}, s_rd}) - debt_cur;
                dp_next    = debt_cur + capx - $signed({{(DEBT_W+1-TOT_W){1'b0}}, w_rd});
                s_raddr    = is_leaf ? idx_reg : lchild;
                state_next = S_CP_B;
            end

            S_CP_B: begin
                wnew     = wsave_reg;
                cml_next = M_SKIP;
                cmr_next = M_SKIP;
                dl_next  = '0;
                dr_next  = '0;
                case (cmode_reg)
                    M_ZERO: begin
                        wnew     = '0;
                        cml_next = M_ZERO;
                        cmr_next = M_ZERO;
                    end
                    M_ACT: begin
                        if (wsave_reg == '0) begin
                            wnew = wsave_reg;
                        end else if (is_leaf) begin
                            wnew = sat32(diff_reg);
                        end else if (diff_reg > capx) begin
                            wnew     = cap_reg;
                            cml_next = M_ACT;
                            cmr_next = M_ACT;
                            dlw      = (dp_reg < lsx) ? dp_reg : lsx;
                            dl_next  = dlw[DEBT_W-1:0];
                            dr_next  = (rdt > 0) ? rdt[DEBT_W-1:0] : '0;
                        end else begin
                            wnew     = sat32(diff_reg);
                            cml_next = M_ZERO;
                            cmr_next = M_ZERO;
                        end
                    end
                    default: begin
                        wnew = wsave_reg;
                    end
                endcase
                w_we    = 1'b1;
                w_wdata = wnew;
                state_next = is_leaf ? S_CP_NX : S_CP_WL;
            end

            S_CP_WL: begin
                m_we       = 1'b1;
                m_waddr    = lchild;
                m_wdata    = {cml_reg, dl_reg};
                state_next = S_CP_WR;
            end

            S_CP_WR: begin
                m_we       = 1'b1;
                m_waddr    = rchild;
                m_wdata    = {cmr_reg, dr_reg};
                state_next = S_CP_NX;
            end

            S_CP_NX: begin
                if (idx_reg == IDX_W'(NODES - 1)) begin
                    rebuild_next = 1'b1;
                    state_next   = S_UP_RDW;
                end else begin
                    idx_next   = idx_reg + IDX_W'(1);
                    state_next = S_CP_RD;
                end
            end

            // rank from the tree: add left subtree sums along the path
            S_QT: begin
                s_raddr = lchild;
                if (is_leaf) begin
                    state_next = S_RES;
                end else begin
                    idx_next   = go_right ? rchild : lchild;
                    depth_next = depth_reg + DEP_W'(1);
                    if (go_right) begin
                        state_next = S_QT_ADD;
                    end
                end
            end

            S_QT_ADD: begin
                acc_next   = acc_reg + s_rd;
                state_next = S_QT;
            end

            S_QB: begin
                if (k_reg < bcnt_reg) begin
                    state_next = S_QB_CHK;
                end else begin
                    state_next = S_RES;
                end
            end

            S_QB_CHK: begin
                if (bv < x_reg) begin
                    acc_next   = acc_reg + {{(SUM_W-WGT_W){1'b0}}, bw};
                    k_next     = k_reg + CNT_W'(1);
                    state_next = S_QB;
                end else begin
                    state_next = S_RES;
                end
            end

            S_RES: begin
                res_valid = 1'b1;
                if (res_ready) begin
                    state_next = S_IDLE;
                end
            end

            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign res_rank = (acc_reg > {{(SUM_W-RANK_W){1'b0}}, RANK_MAX}) ?
                      RANK_MAX : acc_reg[RANK_W-1:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_CLEAR;
            idx_reg      <= '0;
            total_reg    <= '0;
            cap_reg      <= '0;
            ceil_reg     <= '0;
            flushed_reg  <= 1'b0;
            bcnt_reg     <= '0;
            flushing_reg <= 1'b0;
            rebuild_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            idx_reg      <= idx_next;
            total_reg    <= total_next;
            cap_reg      <= cap_next;
            ceil_reg     <= ceil_next;
            flushed_reg  <= flushed_next;
            bcnt_reg     <= bcnt_next;
            flushing_reg <= flushing_next;
            rebuild_reg  <= rebuild_next;
        end
        x_reg     <= x_next;
        wt_reg    <= wt_next;
        depth_reg <= depth_next;
        rem_reg   <= rem_next;
        k_reg     <= k_next;
        acc_reg   <= acc_next;
        wsave_reg <= wsave_next;
        part_reg  <= part_next;
        cmode_reg <= cmode_next;
        diff_reg  <= diff_next;
        dp_reg    <= dp_next;
        cml_reg   <= cml_next;
        cmr_reg   <= cmr_next;
        dl_reg    <= dl_next;
        dr_reg    <= dr_next;
    end

endmodule

// File: rtl/quantile_digest_rank_sketch_top.sv
// q-digest rank sketch over values 0..1023.
// Input channel s_*: one item per insert or rank query. s_tuser is the
// operation (0 insert, 1 query); s_tdata carries value and weight.
// Output channel m_*: one item per query with the estimated rank below value.
// Inserts give no output item. cfg_wen/cfg_wdata write the digest divisor
// (reset 100, 0 acts as 1); write it only while the block is idle.
// Flow through one sequencer with simple dual-port node, sum, context, buffer RAMs:
//   buffered insert: sorted into the buffer, each larger entry moving up one slot
//   tree insert: add to the total and divide for the capacity, walk down topping up
//   each node on the path to capacity, then walk back up refreshing the subtree sums;
//   a compression sweeps the nodes in index order, then rebuilds every sum, and
//   happens each time the total passes the doubled ceiling
//   buffer flush: one tree insert per buffered item, possibly several compressions
//   query: a tree walk adding left subtree sums, or a scan of buffer entries below value
// After reset s_tready stays low while the node weight and sum RAMs are
// cleared. The result sits in an output register; a new item is accepted
// while it waits, but a following query holds until m_tready frees the slot.
module quantile_digest_rank_sketch_top (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [31:0]                 s_tdata,   // value[9:0], weight[25:10]
    input  logic                        s_tuser,   // operation
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [31:0]                 m_tdata,   // rank[30:0]
    input  logic                        cfg_wen,
    input  logic [qdrs_pkg::DIV_W-1:0]  cfg_wdata
);
    import qdrs_pkg::*;

    logic [DIV_W-1:0]  div_reg;
    logic              m_valid_reg;
    logic [RANK_W-1:0] m_rank_reg;
    logic              res_valid, res_ready;
    logic [RANK_W-1:0] res_rank;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            div_reg <= DIV_RESET;
        end else if (cfg_wen) begin
            div_reg <= cfg_wdata;
        end
    end

    qdrs_core u_core (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_op     (s_tuser),
        .in_value  (s_tdata[VAL_W-1:0]),
        .in_weight (s_tdata[VAL_W +: WGT_W]),
        .divisor   (div_reg),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res_rank  (res_rank)
    );

    assign res_ready = !m_valid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (res_valid && res_ready) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
        if (res_valid && res_ready) begin
            m_rank_reg <= res_rank;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {1'b0, m_rank_reg};

endmodule
